// ----- design/pn2_pkg.sv -----
// ============================================================================
// pn2_pkg
// Shared constants, types and the gradient function of the 2-D noise block.
// ============================================================================
`default_nettype none

package pn2_pkg;

  // Lattice and number format
  localparam int TABLE_SIZE = 256;
  localparam int TABLE_W    = $clog2(TABLE_SIZE);
  localparam int VAL_W      = 8;
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 19;

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = 1 << (FRAC_BITS - 1);

  // Quintic fade 6t^5 - 15t^4 + 10t^3
  localparam int FADE_C5 = 6;
  localparam int FADE_C4 = 15;
  localparam int FADE_C3 = 10;

  // Output clamp at +-3.0
  localparam int SAT_LIMIT = 3 * ONE;

  // Corner offset (signed, -1.0 .. 1.0) and gradient widths
  localparam int CW = FRAC_BITS + 1;
  localparam int GW = FRAC_BITS + 3;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } pn2_op_e;

  typedef struct packed {
    logic               we;
    logic [TABLE_W-1:0] addr;
    logic [VAL_W-1:0]   data;
  } pn2_wr_t;

  typedef struct packed {
    logic [VAL_W-1:0] aa;
    logic [VAL_W-1:0] ab;
    logic [VAL_W-1:0] ba;
    logic [VAL_W-1:0] bb;
  } pn2_corner_t;

  // (+-u) + (+-2v); bit 1 of the hash swaps u and v
  function automatic logic signed [GW-1:0] grad(input logic [1:0] h,
                                                input logic signed [CW-1:0] x,
                                                input logic signed [CW-1:0] y);
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    logic signed [GW-1:0] a;
    logic signed [GW-1:0] b;
    u = h[1] ? GW'(y) : GW'(x);
    v = h[1] ? GW'(x) : GW'(y);
    a = h[0] ? -u : u;
    b = h[1] ? -(v <<< 1) : (v <<< 1);
    return a + b;
  endfunction

endpackage

`default_nettype wire

// ----- design/pn2_ram.sv -----
// ============================================================================
// pn2_ram
// Generic RAM: one write port, two read ports, registered read with enable.
// ============================================================================
`default_nettype none

module pn2_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  // read-before-write on an address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

`default_nettype wire

// ----- design/pn2_hash.sv -----
// ============================================================================
// pn2_hash
// Permutation table, held in three copies, and the two-level corner hash.
// ============================================================================
`default_nettype none

module pn2_hash (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire pn2_pkg::pn2_wr_t              wr_i,
  input  wire logic [pn2_pkg::TABLE_W-1:0]   cx_i,
  input  wire logic [pn2_pkg::TABLE_W-1:0]   cy_i,
  output pn2_pkg::pn2_corner_t               corner_o
);

  localparam int TW = pn2_pkg::TABLE_W;
  localparam int VW = pn2_pkg::VAL_W;

  logic [VW-1:0] px0;
  logic [VW-1:0] px1;
  logic [TW-1:0] cy_q;
  logic [TW-1:0] addr_a0;
  logic [TW-1:0] addr_a1;
  logic [TW-1:0] addr_b0;
  logic [TW-1:0] addr_b1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cy_q <= cy_i;
    end
  end

  assign addr_a0 = TW'(px0) + cy_q;
  assign addr_a1 = TW'(px0) + cy_q + TW'(1);
  assign addr_b0 = TW'(px1) + cy_q;
  assign addr_b1 = TW'(px1) + cy_q + TW'(1);

  // level 1: perm[cx], perm[cx+1]
  pn2_ram #(.WIDTH(VW), .DEPTH(pn2_pkg::TABLE_SIZE)) u_ram_x (
    .clk_i     (clk_i),
    .we_i      (wr_i.we),
    .waddr_i   (wr_i.addr),
    .wdata_i   (wr_i.data),
    .re_i      (en_i),
    .raddr_a_i (cx_i),
    .raddr_b_i (cx_i + TW'(1)),
    .rdata_a_o (px0),
    .rdata_b_o (px1)
  );

  // level 2, left column
  pn2_ram #(.WIDTH(VW), .DEPTH(pn2_pkg::TABLE_SIZE)) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (wr_i.we),
    .waddr_i   (wr_i.addr),
    .wdata_i   (wr_i.data),
    .re_i      (en_i),
    .raddr_a_i (addr_a0),
    .raddr_b_i (addr_a1),
    .rdata_a_o (corner_o.aa),
    .rdata_b_o (corner_o.ab)
  );

  // level 2, right column
  pn2_ram #(.WIDTH(VW), .DEPTH(pn2_pkg::TABLE_SIZE)) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (wr_i.we),
    .waddr_i   (wr_i.addr),
    .wdata_i   (wr_i.data),
    .re_i      (en_i),
    .raddr_a_i (addr_b0),
    .raddr_b_i (addr_b1),
    .rdata_a_o (corner_o.ba),
    .rdata_b_o (corner_o.bb)
  );

endmodule

`default_nettype wire

// ----- design/pn2_fade.sv -----
// ============================================================================
// pn2_fade
// Three-multiplier pipeline for the quintic fade of one fraction.
// ============================================================================
`default_nettype none

module pn2_fade (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic [pn2_pkg::FRAC_BITS-1:0]   f_i,
  output logic      [pn2_pkg::FRAC_BITS-1:0]   f_o,
  output logic      [pn2_pkg::FRAC_BITS:0]     s_o
);

  localparam int F   = pn2_pkg::FRAC_BITS;
  localparam int SQW = 2 * F;
  localparam int P3W = 2 * F + 1;
  localparam int QW  = F + 6;
  localparam int SPW = 2 * F + 5;
  localparam int RSW = F + 6;

  logic [F-1:0]   f0_q;
  logic [F-1:0]   f1_q;
  logic [F:0]     t2_q;
  logic [F:0]     t2_d;
  logic [F:0]     t3_q;
  logic [F:0]     t3_d;
  logic [F+3:0]   q_q;
  logic [F+3:0]   q_d;
  logic [F:0]     s_q;
  logic [F:0]     s_d;

  logic [SQW-1:0] sq;
  logic [SQW:0]   sq_r;
  logic [P3W-1:0] cu;
  logic [P3W:0]   cu_r;
  logic [QW-1:0]  q_full;
  logic [SPW-1:0] sp;
  logic [SPW:0]   sp_r;
  logic [RSW-1:0] rs;

  always_comb begin
    sq   = {{F{1'b0}}, f0_q} * {{F{1'b0}}, f0_q};
    sq_r = {1'b0, sq} + {1'b0, SQW'(pn2_pkg::HALF)};
    t2_d = sq_r[SQW:F];

    cu   = P3W'(t2_q) * P3W'(f1_q);
    cu_r = {1'b0, cu} + {1'b0, P3W'(pn2_pkg::HALF)};
    t3_d = cu_r[2*F:F];

    // wraps mod 2^QW; the true value fits as signed
    q_full = QW'(t2_q) * QW'(pn2_pkg::FADE_C5)
           - QW'(f1_q) * QW'(pn2_pkg::FADE_C4)
           + QW'(pn2_pkg::FADE_C3 * pn2_pkg::ONE);
    q_d    = q_full[QW-1] ? '0 : q_full[F+3:0];

    sp   = SPW'(t3_q) * SPW'(q_q);
    sp_r = {1'b0, sp} + {1'b0, SPW'(pn2_pkg::HALF)};
    rs   = sp_r[SPW:F];
    s_d  = (rs > RSW'(pn2_pkg::ONE)) ? (F+1)'(pn2_pkg::ONE) : rs[F:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f0_q <= f_i;
      f1_q <= f0_q;
      t2_q <= t2_d;
      t3_q <= t3_d;
      q_q  <= q_d;
      s_q  <= s_d;
    end
  end

  assign f_o = f1_q;
  assign s_o = s_q;

endmodule

`default_nettype wire

// ----- design/pn2_blend.sv -----
// ============================================================================
// pn2_blend
// Corner gradients, two-level bilinear blend and output clamp.
// ============================================================================
`default_nettype none

module pn2_blend (
  input  wire logic                                 clk_i,
  input  wire logic                                 en_i,
  input  wire logic [pn2_pkg::FRAC_BITS-1:0]        xf_i,
  input  wire logic [pn2_pkg::FRAC_BITS-1:0]        yf_i,
  input  wire pn2_pkg::pn2_corner_t                 corner_i,
  input  wire logic [pn2_pkg::FRAC_BITS:0]          su_i,
  input  wire logic [pn2_pkg::FRAC_BITS:0]          sv_i,
  output logic signed [pn2_pkg::OUT_W-1:0]          noise_o
);

  localparam int F   = pn2_pkg::FRAC_BITS;
  localparam int CW  = pn2_pkg::CW;
  localparam int GW  = pn2_pkg::GW;
  localparam int DW  = F + 4;          // first-level difference
  localparam int PW  = 2 * F + 6;      // first-level product
  localparam int BW  = F + 4;          // first-level blend result
  localparam int EW  = F + 5;          // second-level difference
  localparam int PW2 = 2 * F + 7;      // second-level product
  localparam int RW  = F + 7;          // final sum
  localparam int XW  = RW + pn2_pkg::OUT_W;

  logic signed [CW-1:0]  x0;
  logic signed [CW-1:0]  x1;
  logic signed [CW-1:0]  y0;
  logic signed [CW-1:0]  y1;

  logic signed [GW-1:0]  g_aa_q, g_ab_q, g_ba_q, g_bb_q;
  logic signed [DW-1:0]  d0_q, d1_q;
  logic signed [GW-1:0]  a0_3_q, a1_3_q, a0_4_q, a1_4_q;
  logic signed [PW-1:0]  p0_q, p1_q;
  logic [F:0]            sv4_q, sv5_q, sv6_q;
  logic signed [BW-1:0]  g0_q, g1_q, g0_6_q, g0_7_q;
  logic signed [EW-1:0]  dd_q;
  logic signed [PW2-1:0] p_q;
  logic signed [pn2_pkg::OUT_W-1:0] noise_q;

  logic signed [PW-1:0]  r0, r1;
  logic signed [BW-1:0]  g0_d, g1_d;
  logic signed [PW2-1:0] r2;
  logic signed [RW-1:0]  rr;
  logic signed [RW-1:0]  sat;
  logic signed [XW-1:0]  ext;

  assign x0 = $signed({1'b0, xf_i});
  assign y0 = $signed({1'b0, yf_i});
  assign x1 = x0 - CW'(pn2_pkg::ONE);
  assign y1 = y0 - CW'(pn2_pkg::ONE);

  always_comb begin
    r0   = (p0_q + PW'(pn2_pkg::HALF)) >>> F;
    r1   = (p1_q + PW'(pn2_pkg::HALF)) >>> F;
    g0_d = BW'(a0_4_q) + $signed(r0[BW-1:0]);
    g1_d = BW'(a1_4_q) + $signed(r1[BW-1:0]);

    r2 = (p_q + PW2'(pn2_pkg::HALF)) >>> F;
    rr = RW'(g0_7_q) + $signed(r2[RW-1:0]);
    priority if (rr > RW'(pn2_pkg::SAT_LIMIT)) begin
      sat = RW'(pn2_pkg::SAT_LIMIT);
    end else if (rr < -RW'(pn2_pkg::SAT_LIMIT)) begin
      sat = -RW'(pn2_pkg::SAT_LIMIT);
    end else begin
      sat = rr;
    end
    ext = XW'(sat);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // gradients
      g_aa_q <= pn2_pkg::grad(corner_i.aa[1:0], x0, y0);
      g_ba_q <= pn2_pkg::grad(corner_i.ba[1:0], x1, y0);
      g_ab_q <= pn2_pkg::grad(corner_i.ab[1:0], x0, y1);
      g_bb_q <= pn2_pkg::grad(corner_i.bb[1:0], x1, y1);
      // differences along x
      d0_q   <= DW'(g_ba_q) - DW'(g_aa_q);
      d1_q   <= DW'(g_bb_q) - DW'(g_ab_q);
      a0_3_q <= g_aa_q;
      a1_3_q <= g_ab_q;
      // x blend products; su arrives here
      p0_q   <= PW'($signed({1'b0, su_i})) * PW'(d0_q);
      p1_q   <= PW'($signed({1'b0, su_i})) * PW'(d1_q);
      a0_4_q <= a0_3_q;
      a1_4_q <= a1_3_q;
      sv4_q  <= sv_i;
      // x blend results
      g0_q   <= g0_d;
      g1_q   <= g1_d;
      sv5_q  <= sv4_q;
      // difference along y
      dd_q   <= EW'(g1_q) - EW'(g0_q);
      g0_6_q <= g0_q;
      sv6_q  <= sv5_q;
      // y blend product
      p_q    <= PW2'($signed({1'b0, sv6_q})) * PW2'(dd_q);
      g0_7_q <= g0_6_q;
      // clamped result
      noise_q <= ext[pn2_pkg::OUT_W-1:0];
    end
  end

  assign noise_o = noise_q;

endmodule

`default_nettype wire

// ----- design/perlin_noise_2d.sv -----
// ============================================================================
// perlin_noise_2d
// Two-dimensional gradient noise with a loadable 256-entry permutation table.
// ============================================================================
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item.
//   operation_i = write stores table_value_i at table_index_i and gives no
//   result. operation_i = evaluate takes x_coord_i / y_coord_i (Q16.16) and
//   gives exactly one noise_value_o (signed, 16 fraction bits, clamped to
//   +-3.0) on the output channel (out_valid_o / out_stall_i).
//   Throughput: one transaction per cycle while the pipeline is not held,
//   writes and evaluates mixed freely. A result passes through nine register
//   stages, the first loaded at the edge that accepts its evaluate.
//   The stages are set by the corner hash (two dependent table reads, each a
//   registered RAM read) overlapping with the fade (three chained multiplies)
//   and by the two blend levels (multiply, then round and add).
//   The table sits in three RAM copies with two read ports each, all written
//   together, so the six reads of an item never contend.
//   Writes take effect at acceptance, so every evaluate sees exactly the
//   writes accepted before it.
//   Reset clears only the result valid pipeline; the table is undefined
//   until written. While a result waits and out_stall_i is high the whole
//   pipeline holds and in_stall_o is raised; otherwise input is accepted.
// ============================================================================
`default_nettype none

module perlin_noise_2d (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               operation_i,
  input  wire logic [7:0]                         table_index_i,
  input  wire logic [7:0]                         table_value_i,
  input  wire logic signed [31:0]                 x_coord_i,
  input  wire logic signed [31:0]                 y_coord_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [18:0]                      noise_value_o
);

  localparam int F   = pn2_pkg::FRAC_BITS;
  localparam int TW  = pn2_pkg::TABLE_W;
  localparam int LAT = 9;

  logic                       adv;
  logic                       in_accept;
  logic                       eval_accept;
  logic [LAT-1:0]             vld_q;
  pn2_pkg::pn2_wr_t           wr;
  pn2_pkg::pn2_corner_t       corner;
  logic [F-1:0]               xf_d1;
  logic [F-1:0]               yf_d1;
  logic [F:0]                 su;
  logic [F:0]                 sv;

  // Global pipeline enable: hold only when the output register is full
  // and the receiver stalls.
  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign in_accept   = in_valid_i && adv;
  assign eval_accept = in_accept && (operation_i == pn2_pkg::OP_EVAL);

  assign wr.we   = in_accept && (operation_i == pn2_pkg::OP_WRITE);
  assign wr.addr = table_index_i;
  assign wr.data = table_value_i;

  // Only evaluates carry a valid bit; writes leave a bubble.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], eval_accept};
    end
  end

  // The x cell index goes straight to the first table read; y is registered.
  pn2_hash u_hash (
    .clk_i    (clk_i),
    .en_i     (adv),
    .wr_i     (wr),
    .cx_i     (x_coord_i[F+TW-1:F]),
    .cy_i     (y_coord_i[F+TW-1:F]),
    .corner_o (corner)
  );

  pn2_fade u_fade_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .f_i   (x_coord_i[F-1:0]),
    .f_o   (xf_d1),
    .s_o   (su)
  );

  pn2_fade u_fade_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .f_i   (y_coord_i[F-1:0]),
    .f_o   (yf_d1),
    .s_o   (sv)
  );

  // Final stage of the blend is the output register.
  pn2_blend u_blend (
    .clk_i    (clk_i),
    .en_i     (adv),
    .xf_i     (xf_d1),
    .yf_i     (yf_d1),
    .corner_i (corner),
    .su_i     (su),
    .sv_i     (sv),
    .noise_o  (noise_value_o)
  );

  assign out_valid_o = vld_q[LAT-1];

endmodule

`default_nettype wire
